// ----- rtl/cbsu_pkg.sv -----
`timescale 1ns / 1ps

package cbsu_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  localparam logic [15:0] WORD_BYTES = 16'd2;

  // operation codes carried in req_type
  typedef enum logic [4:0] {
    REQ_PUSH     = 5'd0,
    REQ_POP      = 5'd1,
    REQ_CALL     = 5'd2,
    REQ_CALL_SET = 5'd3,
    REQ_CALL_CLR = 5'd4,
    REQ_RST      = 5'd5,
    REQ_RET      = 5'd6,
    REQ_RET_SET  = 5'd7,
    REQ_RET_CLR  = 5'd8,
    REQ_JP_WORD  = 5'd9,
    REQ_JP_NN    = 5'd10,
    REQ_JR       = 5'd11,
    REQ_JP_SET   = 5'd12,
    REQ_JP_CLR   = 5'd13,
    REQ_JR_SET   = 5'd14,
    REQ_JR_CLR   = 5'd15,
    REQ_DJNZ     = 5'd16
  } req_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CALL_EXTRA = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RET_EXTRA  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_EXTRA = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REL_EXTRA  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_EXTRA = 3'd4;

  typedef struct packed {
    logic [3:0] call_extra;
    logic [3:0] ret_extra;
    logic [3:0] jump_extra;
    logic [3:0] rel_extra;
    logic [3:0] loop_extra;
  } cfg_t;

  typedef struct packed {
    logic [4:0]  req_type;
    logic [7:0]  flag_byte;
    logic [15:0] operand_word;
    logic [7:0]  imm_low;
    logic [7:0]  imm_high;
    logic [7:0]  stack_low;
    logic [7:0]  stack_high;
    logic [7:0]  count_in;
  } op_t;

  typedef struct packed {
    logic [15:0] pc_out;
    logic [15:0] sp_out;
    logic        write_enable;
    logic [15:0] write_addr;
    logic [15:0] write_data;
    logic [15:0] pop_data;
    logic [7:0]  count_out;
    logic        taken;
    logic [3:0]  extra_cycles;
  } res_t;

  // pc + 1 + sign-extended displacement
  function automatic logic [15:0] rel_target(input logic [15:0] pc, input logic [7:0] disp);
    rel_target = pc + 16'd1 + {{8{disp[7]}}, disp};
  endfunction

endpackage

// ----- rtl/cpu_branch_and_stack_unit_core.sv -----
`timescale 1ns / 1ps
// Control-flow and stack unit of an 8-bit CPU: keeps pc and sp and works out
// one branch, call, return, push, pop or loop operation per input word.
// Input channel: in_valid / in_stall with one port per field of the operation
// (opcode class, flags, operand word, bytes at pc and sp, count register B).
// Output channel: out_valid / out_stall with the new pc and sp, the stack
// write request, the popped word, the new B, the taken flag and the extra
// cycles a taken condition costs.
// Pipeline: an accepted word is loaded into the input register and then into
// the result register, where the word is then on the output.
// Throughput: one word per cycle unless out_stall holds; pc and sp advance
// as a word moves from the input register to the result register, so the
// next word sees them at once. When out_stall holds a full result register,
// the input register holds too and in_stall rises while it is occupied.
// Configuration: cfg_we / cfg_index / cfg_data write the five extra-cycle
// registers; write them only while the unit is idle.
// Reset (rst, synchronous): pc and sp clear to zero, both stages empty and
// the extra-cycle registers return to 7, 6, 0, 5, 5.
module cpu_branch_and_stack_unit_core import cbsu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [4:0]            req_type,
  input  logic [7:0]            flag_byte,
  input  logic [15:0]           operand_word,
  input  logic [7:0]            imm_low,
  input  logic [7:0]            imm_high,
  input  logic [7:0]            stack_low,
  input  logic [7:0]            stack_high,
  input  logic [7:0]            count_in,
  // output channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [15:0]           pc_out,
  output logic [15:0]           sp_out,
  output logic                  write_enable,
  output logic [15:0]           write_addr,
  output logic [15:0]           write_data,
  output logic [15:0]           pop_data,
  output logic [7:0]            count_out,
  output logic                  taken,
  output logic [3:0]            extra_cycles
);

  cfg_t        cfg;
  op_t         op_reg;
  logic        op_valid;
  res_t        res_next;
  res_t        res_reg;
  logic        res_load;
  logic        op_load;
  logic [15:0] prog_counter;
  logic [15:0] stack_pointer;

  cbsu_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cbsu_exec u_exec (
    .op  (op_reg),
    .pc  (prog_counter),
    .sp  (stack_pointer),
    .cfg (cfg),
    .res (res_next)
  );

  // The result register is free when empty or being drained this cycle.
  assign res_load = op_valid && (!out_valid || !out_stall);
  // The input register takes a word when empty or when its word moves on.
  assign in_stall = op_valid && !res_load;
  assign op_load  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (op_load) begin
      op_valid <= 1'b1;
    end else if (res_load) begin
      op_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op_load) begin
      op_reg.req_type     <= req_type;
      op_reg.flag_byte    <= flag_byte;
      op_reg.operand_word <= operand_word;
      op_reg.imm_low      <= imm_low;
      op_reg.imm_high     <= imm_high;
      op_reg.stack_low    <= stack_low;
      op_reg.stack_high   <= stack_high;
      op_reg.count_in     <= count_in;
    end
  end

  // architectural state: advance as each word commits to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      prog_counter  <= 16'd0;
      stack_pointer <= 16'd0;
    end else if (res_load) begin
      prog_counter  <= res_next.pc_out;
      stack_pointer <= res_next.sp_out;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_reg <= res_next;
    end
  end

  assign pc_out       = res_reg.pc_out;
  assign sp_out       = res_reg.sp_out;
  assign write_enable = res_reg.write_enable;
  assign write_addr   = res_reg.write_addr;
  assign write_data   = res_reg.write_data;
  assign pop_data     = res_reg.pop_data;
  assign count_out    = res_reg.count_out;
  assign taken        = res_reg.taken;
  assign extra_cycles = res_reg.extra_cycles;

endmodule

// ----- rtl/cbsu_cfg_regs.sv -----
`timescale 1ns / 1ps

module cbsu_cfg_regs import cbsu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.call_extra <= 4'd7;
      cfg.ret_extra  <= 4'd6;
      cfg.jump_extra <= 4'd0;
      cfg.rel_extra  <= 4'd5;
      cfg.loop_extra <= 4'd5;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CALL_EXTRA: cfg.call_extra <= cfg_data;
        CFG_RET_EXTRA:  cfg.ret_extra  <= cfg_data;
        CFG_JUMP_EXTRA: cfg.jump_extra <= cfg_data;
        CFG_REL_EXTRA:  cfg.rel_extra  <= cfg_data;
        CFG_LOOP_EXTRA: cfg.loop_extra <= cfg_data;
        default: ; // unused index: drop the write
      endcase
    end
  end

endmodule

// ----- rtl/cbsu_exec.sv -----
`timescale 1ns / 1ps

module cbsu_exec import cbsu_pkg::*; (
  input  op_t         op,
  input  logic [15:0] pc,
  input  logic [15:0] sp,
  input  cfg_t        cfg,
  output res_t        res
);

  logic        hit;
  logic        cond;
  logic        push;
  logic        pop;
  logic [15:0] pc_next;
  logic [15:0] wdata;
  logic [3:0]  extra;
  logic [7:0]  count_next;
  logic [15:0] imm;
  logic [15:0] stk;
  logic [15:0] pc_plus1;
  logic [15:0] pc_plus2;
  logic [15:0] pc_rel;
  logic [15:0] sp_down;
  logic [15:0] sp_up;

  assign hit      = |(op.flag_byte & op.operand_word[7:0]);
  assign imm      = {op.imm_high, op.imm_low};
  assign stk      = {op.stack_high, op.stack_low};
  assign pc_plus1 = pc + 16'd1;
  assign pc_plus2 = pc + WORD_BYTES;
  assign pc_rel   = rel_target(pc, op.imm_low);
  assign sp_down  = sp - WORD_BYTES;
  assign sp_up    = sp + WORD_BYTES;

  always_comb begin
    cond       = 1'b0;
    push       = 1'b0;
    pop        = 1'b0;
    pc_next    = pc;
    wdata      = 16'd0;
    extra      = 4'd0;
    count_next = op.count_in;
    case (op.req_type)
      REQ_PUSH: begin
        push  = 1'b1;
        wdata = op.operand_word;
      end
      REQ_POP: begin
        pop = 1'b1;
      end
      REQ_CALL: begin
        push    = 1'b1;
        wdata   = pc_plus2;
        pc_next = imm;
      end
      REQ_CALL_SET, REQ_CALL_CLR: begin
        cond = (op.req_type == REQ_CALL_SET) ? hit : !hit;
        if (cond) begin
          push    = 1'b1;
          wdata   = pc_plus2;
          pc_next = imm;
          extra   = cfg.call_extra;
        end else begin
          pc_next = pc_plus2;
        end
      end
      REQ_RST: begin
        push    = 1'b1;
        wdata   = pc;
        pc_next = op.operand_word;
      end
      REQ_RET: begin
        pop     = 1'b1;
        pc_next = stk;
      end
      REQ_RET_SET, REQ_RET_CLR: begin
        cond = (op.req_type == REQ_RET_SET) ? hit : !hit;
        if (cond) begin
          pop     = 1'b1;
          pc_next = stk;
          extra   = cfg.ret_extra;
        end
      end
      REQ_JP_WORD: pc_next = op.operand_word;
      REQ_JP_NN:   pc_next = imm;
      REQ_JR:      pc_next = pc_rel;
      REQ_JP_SET, REQ_JP_CLR: begin
        cond    = (op.req_type == REQ_JP_SET) ? hit : !hit;
        pc_next = cond ? imm : pc_plus2;
        extra   = cond ? cfg.jump_extra : 4'd0;
      end
      REQ_JR_SET, REQ_JR_CLR: begin
        cond    = (op.req_type == REQ_JR_SET) ? hit : !hit;
        pc_next = cond ? pc_rel : pc_plus1;
        extra   = cond ? cfg.rel_extra : 4'd0;
      end
      REQ_DJNZ: begin
        count_next = op.count_in - 8'd1;
        cond       = (count_next != 8'd0);
        pc_next    = cond ? pc_rel : pc_plus1;
        extra      = cond ? cfg.loop_extra : 4'd0;
      end
      default: ; // unknown code: no operation
    endcase
  end

  always_comb begin
    res.pc_out       = pc_next;
    res.sp_out       = push ? sp_down : (pop ? sp_up : sp);
    res.write_enable = push;
    res.write_addr   = push ? sp_down : 16'd0;
    res.write_data   = push ? wdata : 16'd0;
    res.pop_data     = pop ? stk : 16'd0;
    res.count_out    = count_next;
    res.taken        = cond;
    res.extra_cycles = extra;
  end

endmodule

// ----- rtl/cbsu_checker.sv -----
`timescale 1ns / 1ps

module cbsu_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] pc_out,
  input logic [15:0] sp_out,
  input logic        write_enable,
  input logic [15:0] write_addr,
  input logic [15:0] write_data,
  input logic        taken,
  input logic [3:0]  extra_cycles
);

  // a stalled word stays on the port
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pc_out) && $stable(sp_out))
    else $error("stalled result word changed");

  // a push always writes just below the old stack pointer, i.e. at the new one
  assert property (@(posedge clk) disable iff (rst)
    out_valid && write_enable |-> write_addr == sp_out)
    else $error("stack write address differs from new sp");

  // no write request carries address or data
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_enable |-> write_addr == 16'd0 && write_data == 16'd0)
    else $error("idle write request carries payload");

  // extra cycles only when the condition held
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !taken |-> extra_cycles == 4'd0)
    else $error("extra cycles without a taken condition");

endmodule

bind cpu_branch_and_stack_unit_core cbsu_checker u_cbsu_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .pc_out       (pc_out),
  .sp_out       (sp_out),
  .write_enable (write_enable),
  .write_addr   (write_addr),
  .write_data   (write_data),
  .taken        (taken),
  .extra_cycles (extra_cycles)
);
